[rtl/core/qtl_pkg.sv]
// qtl_pkg: shared constants, codes and control structs of the q table learning engine
// no dependencies; imported by every module of the engine
`timescale 1ns / 1ps

package qtl_pkg;

  // default sizes of the table
  localparam int unsigned DEF_NUM_STATES  = 16;
  localparam int unsigned DEF_NUM_ACTIONS = 12;
  localparam int unsigned DEF_VALUE_BITS  = 24;

  // fixed point format and port field widths
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned IO_VAL_W  = 24;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SIDX_W    = 4;
  localparam int unsigned AIDX_W    = 4;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned CHOSEN_W  = 4;
  localparam int unsigned BEST_W    = 5;
  localparam int unsigned MAXV_W    = 23;

  // configuration port
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_DISC   = 2'd2;

  localparam logic [CFG_W-1:0] THRESH_RST = 16'd6554;
  localparam logic [CFG_W-1:0] RATE_RST   = 16'd32768;
  localparam logic [CFG_W-1:0] DISC_RST   = 16'd58982;

  // shared multiplier: operand times one byte of a fraction, then shift by a byte
  localparam int unsigned MAC_BW    = 8;
  localparam int unsigned MAC_SHIFT = 8;

  // request operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_SELECT = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  // row scan unit control
  typedef struct packed {
    logic clear;
    logic vld;
    logic greedy_en;
  } scan_ctrl_t;

  // multiply accumulate unit control
  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctrl_t;

endpackage

[rtl/core/qtl_mem.sv]
// qtl_mem: q table storage, one write and one registered read port
// clears itself after reset one entry a cycle; uses qtl_pkg
`timescale 1ns / 1ps

module qtl_mem import qtl_pkg::*; #(
  parameter int unsigned NUM_STATES  = DEF_NUM_STATES,
  parameter int unsigned NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS,
  localparam int unsigned ACT_W      = $clog2(NUM_ACTIONS),
  localparam int unsigned ROW_W      = $clog2(NUM_STATES),
  localparam int unsigned ADDR_W     = ROW_W + ACT_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [ADDR_W-1:0]            wr_addr_i,
  input  logic signed [VALUE_BITS-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [ADDR_W-1:0]            rd_addr_i,
  output logic signed [VALUE_BITS-1:0] rd_data_o,
  output logic                         clearing_o
);

  localparam int unsigned MEM_DEPTH = NUM_STATES << ACT_W;

  logic signed [VALUE_BITS-1:0] mem [MEM_DEPTH];
  logic signed [VALUE_BITS-1:0] rd_q;
  logic [ADDR_W-1:0]            clr_q;
  logic                         clearing_q;

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  // write port, the sweep has priority
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clearing_q;

endmodule

[rtl/core/qtl_mac.sv]
// qtl_mac: shared multiply accumulate unit, acc = (a * b + acc) >>> 8
// two passes scale a signed value by a 16-bit fraction; uses qtl_pkg
`timescale 1ns / 1ps

module qtl_mac import qtl_pkg::*; #(
  parameter int unsigned OP_W = 28
) (
  input  logic                   clk_i,
  input  mac_ctrl_t              ctrl_i,
  input  logic signed [OP_W-1:0] a_i,
  input  logic [MAC_BW-1:0]      b_i,
  output logic signed [OP_W-1:0] acc_o
);

  localparam int unsigned PW = OP_W + MAC_BW + 1;
  localparam int unsigned AW = PW + 1;

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc_in;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] acc_q;

  // signed operand times unsigned byte
  assign prod   = PW'(a_i) * PW'($signed({1'b0, b_i}));
  assign acc_in = ctrl_i.clear ? '0 : acc_q;
  assign sum    = AW'(prod) + acc_in;

  // arithmetic shift gives the floor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= sum >>> MAC_SHIFT;
    end
  end

  assign acc_o = acc_q[OP_W-1:0];

endmodule

[rtl/core/qtl_scan.sv]
// qtl_scan: row scan compare unit, one table entry a cycle
// tracks best value above zero, greedy choice above -1.0 and the reported entry; uses qtl_pkg
`timescale 1ns / 1ps

module qtl_scan import qtl_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned ACT_W      = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scan_ctrl_t                   ctrl_i,
  input  logic [ACT_W-1:0]             idx_i,
  input  logic signed [VALUE_BITS-1:0] data_i,
  input  logic [ACT_W-1:0]             last_i,
  output logic                         best_found_o,
  output logic [ACT_W-1:0]             best_idx_o,
  output logic signed [VALUE_BITS-1:0] best_val_o,
  output logic                         greedy_found_o,
  output logic [ACT_W-1:0]             greedy_idx_o,
  output logic signed [VALUE_BITS-1:0] rep_o
);

  localparam int unsigned CW = ((VALUE_BITS > FRAC_BITS + 1) ? VALUE_BITS : FRAC_BITS + 1) + 1;
  localparam int          GREEDY_FLOOR = -(1 << FRAC_BITS);

  logic                         best_found_q;
  logic [ACT_W-1:0]             best_idx_q;
  logic signed [VALUE_BITS-1:0] best_val_q;
  logic                         greedy_found_q;
  logic [ACT_W-1:0]             greedy_idx_q;
  logic signed [CW-1:0]         gmax_q;
  logic signed [VALUE_BITS-1:0] rep_q;
  logic                         above_best;
  logic                         above_greedy;

  // strict compares keep the first of equal values
  assign above_best   = data_i > best_val_q;
  assign above_greedy = ctrl_i.greedy_en && (CW'(data_i) > gmax_q);

  // found flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q   <= 1'b0;
      greedy_found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      best_found_q   <= 1'b0;
      greedy_found_q <= 1'b0;
    end else if (ctrl_i.vld) begin
      if (above_best) begin
        best_found_q <= 1'b1;
      end
      if (above_greedy) begin
        greedy_found_q <= 1'b1;
      end
    end
  end

  // running maxima and reported entry
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      best_val_q <= '0;
      gmax_q     <= CW'(GREEDY_FLOOR);
    end else if (ctrl_i.vld) begin
      if (above_best) begin
        best_val_q <= data_i;
        best_idx_q <= idx_i;
      end
      if (above_greedy) begin
        gmax_q       <= CW'(data_i);
        greedy_idx_q <= idx_i;
        rep_q        <= data_i;
      end else if (!greedy_found_q && idx_i == last_i) begin
        rep_q <= data_i;
      end
    end
  end

  assign best_found_o   = best_found_q;
  assign best_idx_o     = best_idx_q;
  assign best_val_o     = best_val_q;
  assign greedy_found_o = greedy_found_q;
  assign greedy_idx_o   = greedy_idx_q;
  assign rep_o          = rep_q;

endmodule

[rtl/core/q_table_learning_engine.sv]
// q_table_learning_engine: tabular q learning with epsilon greedy action select
// sequencer, config registers and top level; uses qtl_pkg, qtl_mem, qtl_mac, qtl_scan
//
//   channel   signals                                   direction  handshake
//   request   start, busy, kind_i .. entry_value_i      in         start && !busy
//   result    done_o, chosen_action_o .. new_value_o    out        done_o, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready tied high
//             prdata, pready
//
// select and query scan the row through the single read port before done_o; load
// first writes the entry, and update first reads it, makes the two byte passes of
// the shared multiplier for each of the two scalings and writes the new value.
// after reset the table is cleared one entry a cycle, all NUM_STATES << clog2(NUM_ACTIONS)
// entries (256 at the defaults), with busy high; config writes are taken meanwhile.
// the receiver cannot stall: each result shows for one cycle with done_o.
`timescale 1ns / 1ps

module q_table_learning_engine import qtl_pkg::*; #(
  parameter int unsigned NUM_STATES  = DEF_NUM_STATES,
  parameter int unsigned NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int unsigned VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  // request
  input  logic                       start,
  output logic                       busy,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic [SIDX_W-1:0]          state_index_i,
  input  logic [AIDX_W-1:0]          action_index_i,
  input  logic [DRAW_W-1:0]          explore_draw_i,
  input  logic [AIDX_W-1:0]          random_action_i,
  input  logic signed [IO_VAL_W-1:0] reward_value_i,
  input  logic signed [IO_VAL_W-1:0] next_value_i,
  input  logic signed [IO_VAL_W-1:0] entry_value_i,
  // result
  output logic                       done_o,
  output logic [CHOSEN_W-1:0]        chosen_action_o,
  output logic signed [BEST_W-1:0]   best_action_o,
  output logic [MAXV_W-1:0]          max_value_o,
  output logic signed [IO_VAL_W-1:0] new_value_o
);

  localparam int unsigned ACT_W  = $clog2(NUM_ACTIONS);
  localparam int unsigned ROW_W  = $clog2(NUM_STATES);
  localparam int unsigned ADDR_W = ROW_W + ACT_W;
  localparam int unsigned DW     = ((VALUE_BITS > IO_VAL_W + 1) ? VALUE_BITS : IO_VAL_W + 1) + 2;
  localparam int unsigned SW     = DW + 1;

  localparam logic signed [SW-1:0] VAL_MAX =
    SW'((longint'(1) << (VALUE_BITS - 1)) - longint'(1));
  localparam logic signed [SW-1:0] VAL_MIN = -VAL_MAX - SW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_DIFF,
    S_UPD_SCL_LO,
    S_UPD_SCL_HI,
    S_UPD_WR,
    S_LOAD_WR,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  // row = state index modulo the row count, by repeated subtraction
  function automatic logic [ROW_W-1:0] row_of(input logic [SIDX_W-1:0] s);
    int unsigned r;
    r = 32'(s);
    for (int k = 0; k < 8; k++) begin
      if (r >= NUM_STATES) begin
        r = r - NUM_STATES;
      end
    end
    return r[ROW_W-1:0];
  endfunction

  // out of range action goes to the last action
  function automatic logic [ACT_W-1:0] act_clamp(input logic [AIDX_W-1:0] v);
    int unsigned a;
    a = 32'(v);
    if (a >= NUM_ACTIONS) begin
      a = NUM_ACTIONS - 1;
    end
    return a[ACT_W-1:0];
  endfunction

  function automatic logic [ACT_W-1:0] act_trunc(input logic [AIDX_W-1:0] v);
    int unsigned a;
    a = 32'(v);
    return a[ACT_W-1:0];
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] clamp_val(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    priority if (x > VAL_MAX) begin
      y = VAL_MAX;
    end else if (x < VAL_MIN) begin
      y = VAL_MIN;
    end else begin
      y = x;
    end
    return y[VALUE_BITS-1:0];
  endfunction

  function automatic logic [CHOSEN_W-1:0] to_chosen(input logic [ACT_W-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[CHOSEN_W-1:0];
  endfunction

  function automatic logic [BEST_W-1:0] to_best(input logic found, input logic [ACT_W-1:0] a);
    logic [31:0] w;
    w = found ? 32'(a) : '1;
    return w[BEST_W-1:0];
  endfunction

  // config registers
  logic [CFG_W-1:0] thresh_q;
  logic [CFG_W-1:0] rate_q;
  logic [CFG_W-1:0] disc_q;
  logic             cfg_wr;

  // sequencer state
  state_e           state_q;
  logic [ACT_W-1:0] last_q;
  logic             greedy_q;
  logic [ACT_W-1:0] scan_idx_q;
  logic [ACT_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic             done_q;

  // latched request fields and intermediate values
  kind_e                        kind_q;
  logic [ROW_W-1:0]             row_q;
  logic [ACT_W-1:0]             col_q;
  logic                         col_ok_q;
  logic signed [IO_VAL_W-1:0]   reward_q;
  logic signed [IO_VAL_W-1:0]   next_q;
  logic signed [IO_VAL_W-1:0]   entry_q;
  logic signed [DW-1:0]         d_q;
  logic signed [VALUE_BITS-1:0] rep_q;

  // result registers
  logic [CHOSEN_W-1:0]          chosen_q;
  logic [BEST_W-1:0]            best_q;
  logic [MAXV_W-1:0]            maxv_q;
  logic [IO_VAL_W-1:0]          newv_q;

  // datapath wiring
  logic                         accept;
  logic                         explore;
  logic                         mem_clearing;
  logic                         mem_wr_en;
  logic [ADDR_W-1:0]            mem_wr_addr;
  logic signed [VALUE_BITS-1:0] mem_wr_data;
  logic                         mem_rd_en;
  logic [ADDR_W-1:0]            mem_rd_addr;
  logic signed [VALUE_BITS-1:0] mem_rd_data;
  mac_ctrl_t                    mac_ctrl;
  logic signed [DW-1:0]         mac_a;
  logic [MAC_BW-1:0]            mac_b;
  logic signed [DW-1:0]         mac_acc;
  scan_ctrl_t                   scan_ctrl;
  logic                         scan_clear;
  logic                         sc_best_found;
  logic [ACT_W-1:0]             sc_best_idx;
  logic signed [VALUE_BITS-1:0] sc_best_val;
  logic                         sc_greedy_found;
  logic [ACT_W-1:0]             sc_greedy_idx;
  logic signed [VALUE_BITS-1:0] sc_rep;
  logic signed [VALUE_BITS-1:0] upd_new;
  logic signed [VALUE_BITS-1:0] load_val;
  logic [ACT_W-1:0]             last_new;
  logic signed [VALUE_BITS-1:0] rep_fin;
  logic [63:0]                  maxv_ext;
  logic [63:0]                  newv_ext;

  assign busy     = (state_q != S_IDLE) || mem_clearing;
  assign accept   = start && !busy;
  assign explore  = explore_draw_i < thresh_q;
  assign upd_new  = clamp_val(SW'(mem_rd_data) + SW'(mac_acc));
  assign load_val = clamp_val(SW'(entry_q));

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      rate_q   <= RATE_RST;
      disc_q   <= DISC_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESH: thresh_q <= pwdata[CFG_W-1:0];
        REG_RATE:   rate_q   <= pwdata[CFG_W-1:0];
        REG_DISC:   disc_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESH: prdata = APB_DW'(thresh_q);
      REG_RATE:   prdata = APB_DW'(rate_q);
      REG_DISC:   prdata = APB_DW'(disc_q);
      default:    prdata = '0;
    endcase
  end

  // memory, multiplier and scan control per state
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = {row_q, last_q};
    mem_wr_data = upd_new;
    mem_rd_en   = 1'b0;
    mem_rd_addr = {row_q, scan_idx_q};
    mac_ctrl    = '0;
    mac_a       = DW'(next_q);
    mac_b       = disc_q[MAC_BW-1:0];
    scan_clear  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        scan_clear = accept && ((kind_e'(kind_i) == KIND_SELECT) ||
                                (kind_e'(kind_i) == KIND_QUERY));
      end
      S_UPD_RD: begin
        mem_rd_en      = 1'b1;
        mem_rd_addr    = {row_q, last_q};
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      S_UPD_MUL: begin
        mac_ctrl.en = 1'b1;
        mac_b       = disc_q[CFG_W-1:MAC_BW];
      end
      S_UPD_DIFF: ;
      S_UPD_SCL_LO: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_a          = d_q;
        mac_b          = rate_q[MAC_BW-1:0];
      end
      S_UPD_SCL_HI: begin
        mac_ctrl.en = 1'b1;
        mac_a       = d_q;
        mac_b       = rate_q[CFG_W-1:MAC_BW];
      end
      S_UPD_WR: begin
        mem_wr_en  = 1'b1;
        scan_clear = 1'b1;
      end
      S_LOAD_WR: begin
        mem_wr_en   = col_ok_q;
        mem_wr_addr = {row_q, col_q};
        mem_wr_data = load_val;
        scan_clear  = 1'b1;
      end
      S_SCAN: begin
        mem_rd_en = 1'b1;
      end
      S_DRAIN, S_FIN: ;
    endcase
  end

  assign scan_ctrl.clear     = scan_clear;
  assign scan_ctrl.vld       = cmp_vld_q;
  assign scan_ctrl.greedy_en = greedy_q;

  // final action and reported entry
  assign last_new = (greedy_q && sc_greedy_found) ? sc_greedy_idx : last_q;
  assign rep_fin  = ((kind_q == KIND_SELECT) || (kind_q == KIND_QUERY)) ? sc_rep : rep_q;
  assign maxv_ext = 64'(sc_best_val[VALUE_BITS-2:0]);
  assign newv_ext = 64'(rep_fin[VALUE_BITS-1:0]);

  // latch request fields, difference and update or load value
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(kind_i);
      row_q    <= row_of(state_index_i);
      col_q    <= act_trunc(action_index_i);
      col_ok_q <= 32'(action_index_i) < NUM_ACTIONS;
      reward_q <= reward_value_i;
      next_q   <= next_value_i;
      entry_q  <= entry_value_i;
    end
    if (state_q == S_UPD_DIFF) begin
      d_q <= DW'(reward_q) + mac_acc - DW'(mem_rd_data);
    end
    if (state_q == S_UPD_WR) begin
      rep_q <= upd_new;
    end
    if (state_q == S_LOAD_WR) begin
      rep_q <= col_ok_q ? load_val : '0;
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_q     <= '0;
      greedy_q   <= 1'b0;
      scan_idx_q <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
      done_q     <= 1'b0;
      chosen_q   <= '0;
      best_q     <= '0;
      maxv_q     <= '0;
      newv_q     <= '0;
    end else begin
      done_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            scan_idx_q <= '0;
            greedy_q   <= (kind_e'(kind_i) == KIND_SELECT) && !explore;
            unique case (kind_e'(kind_i))
              KIND_SELECT: begin
                if (explore) begin
                  last_q <= act_clamp(random_action_i);
                end
                state_q <= S_SCAN;
              end
              KIND_UPDATE: state_q <= S_UPD_RD;
              KIND_LOAD:   state_q <= S_LOAD_WR;
              KIND_QUERY:  state_q <= S_SCAN;
            endcase
          end
        end
        S_UPD_RD:     state_q <= S_UPD_MUL;
        S_UPD_MUL:    state_q <= S_UPD_DIFF;
        S_UPD_DIFF:   state_q <= S_UPD_SCL_LO;
        S_UPD_SCL_LO: state_q <= S_UPD_SCL_HI;
        S_UPD_SCL_HI: state_q <= S_UPD_WR;
        S_UPD_WR:     state_q <= S_SCAN;
        S_LOAD_WR:    state_q <= S_SCAN;
        S_SCAN: begin
          cmp_vld_q <= 1'b1;
          cmp_idx_q <= scan_idx_q;
          if (scan_idx_q == ACT_W'(NUM_ACTIONS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        S_DRAIN: state_q <= S_FIN;
        S_FIN: begin
          last_q   <= last_new;
          chosen_q <= to_chosen(last_new);
          best_q   <= to_best(sc_best_found, sc_best_idx);
          maxv_q   <= maxv_ext[MAXV_W-1:0];
          newv_q   <= newv_ext[IO_VAL_W-1:0];
          done_q   <= 1'b1;
          state_q  <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign chosen_action_o = chosen_q;
  assign best_action_o   = best_q;
  assign max_value_o     = maxv_q;
  assign new_value_o     = newv_q;

  // q table storage
  qtl_mem #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (mem_wr_addr),
    .wr_data_i  (mem_wr_data),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (mem_rd_addr),
    .rd_data_o  (mem_rd_data),
    .clearing_o (mem_clearing)
  );

  // shared multiplier for discount and learning rate scaling
  qtl_mac #(
    .OP_W (DW)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // row scan compare unit
  qtl_scan #(
    .VALUE_BITS (VALUE_BITS),
    .ACT_W      (ACT_W)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (scan_ctrl),
    .idx_i          (cmp_idx_q),
    .data_i         (mem_rd_data),
    .last_i         (last_q),
    .best_found_o   (sc_best_found),
    .best_idx_o     (sc_best_idx),
    .best_val_o     (sc_best_val),
    .greedy_found_o (sc_greedy_found),
    .greedy_idx_o   (sc_greedy_idx),
    .rep_o          (sc_rep)
  );

endmodule

[rtl/core/qtl_checker.sv]
// qtl_checker: port level checks of the q table learning engine
// bound to q_table_learning_engine at the end of this file; uses qtl_pkg
`timescale 1ns / 1ps

module qtl_checker import qtl_pkg::*; #(
  parameter int unsigned NUM_ACTIONS = DEF_NUM_ACTIONS
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic [CHOSEN_W-1:0]      chosen_action_o,
  input logic signed [BEST_W-1:0] best_action_o,
  input logic [MAXV_W-1:0]        max_value_o
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepted request");

  // a result only comes out of a request in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without request in progress");

  // results are single cycle strobes
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // no positive entry means the row maximum reads zero
  a_no_best_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (NUM_ACTIONS < 32) && (best_action_o == 5'h1f) |-> max_value_o == '0)
    else $error("max value nonzero without best action");

  // chosen action stays inside the row
  a_chosen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (NUM_ACTIONS <= 16) |-> 32'(chosen_action_o) < NUM_ACTIONS)
    else $error("chosen action out of range");

endmodule

bind q_table_learning_engine qtl_checker #(
  .NUM_ACTIONS (NUM_ACTIONS)
) u_qtl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .chosen_action_o (chosen_action_o),
  .best_action_o   (best_action_o),
  .max_value_o     (max_value_o)
);
